### design/rbi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared widths, register indexes and stage control types of the bilinear
// image resizer.
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int PIX_W   = 32;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int FRAC_W  = 8;
    // 9.8 source position, integer part up to SIZE_W bits
    localparam int POS_W   = SIZE_W + FRAC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic [PIX_W-1:0] LANE_MASK_LO = 32'h00ff00ff;
    localparam logic [PIX_W-1:0] LANE_MASK_HI = 32'hff00ff00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_DST_W = 2'd2,
        CFG_DST_H = 2'd3
    } t_cfg_idx;

    // Control carried beside the four fetched pixels into the blend stages
    typedef struct packed {
        logic              valid;
        logic              oor;
        logic [FRAC_W-1:0] xf;
        logic [FRAC_W-1:0] yf;
    } t_px_ctl;

endpackage
`default_nettype wire

### design/rbi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbi_div
// Restoring divider, one quotient bit per cycle. Computes the 9.8 source step
// (size << 8) / target size after reset or a register write.
// ----------------------------------------------------------------------------
module rbi_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [rbi_pkg::POS_W-1:0]   i_dividend,
    input  wire [rbi_pkg::SIZE_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [rbi_pkg::POS_W-1:0]  o_quot
);
    import rbi_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_q;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;

    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              ge;
    logic [SIZE_W-1:0] n_rem;
    logic [POS_W-1:0]  n_q;

    always_comb begin
        trial = {r_rem, r_q[POS_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        n_q   = {r_q[POS_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(POS_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // dividend bits shift out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule
`default_nettype wire

### design/rbi_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbi_bank
// One parity bank of the source image: one write port, one read port,
// registered read data with read-before-write on the same entry.
// ----------------------------------------------------------------------------
module rbi_bank #(
    parameter int DEPTH = 1,
    parameter int AW    = 1
) (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [AW-1:0]               i_waddr,
    input  wire [rbi_pkg::PIX_W-1:0]   i_wdata,
    input  wire [AW-1:0]               i_raddr,
    output logic [rbi_pkg::PIX_W-1:0]  o_rdata
);
    import rbi_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### design/rbi_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbi_lerp
// Two blend stages: horizontal blend of both rows, then vertical blend into
// the output register. Channels are blended in packed pairs, modulo 2^32.
// ----------------------------------------------------------------------------
module rbi_lerp (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire rbi_pkg::t_px_ctl      i_ctl,
    input  wire [rbi_pkg::PIX_W-1:0]   i_top_l,
    input  wire [rbi_pkg::PIX_W-1:0]   i_top_r,
    input  wire [rbi_pkg::PIX_W-1:0]   i_bot_l,
    input  wire [rbi_pkg::PIX_W-1:0]   i_bot_r,
    output logic                       o_valid,
    output logic [rbi_pkg::PIX_W-1:0]  o_pixel,
    output logic                       o_oor
);
    import rbi_pkg::*;

    function automatic logic [PIX_W-1:0] lerp_pair(
        input logic [PIX_W-1:0]  a,
        input logic [PIX_W-1:0]  b,
        input logic [FRAC_W-1:0] f
    );
        logic [PIX_W-1:0] lo_a, lo_b, hi_a, hi_b;
        logic [PIX_W-1:0] lo_p, hi_p, lo, hi;
        lo_a = a & LANE_MASK_LO;
        lo_b = b & LANE_MASK_LO;
        hi_a = (a >> 8) & LANE_MASK_LO;
        hi_b = (b >> 8) & LANE_MASK_LO;
        lo_p = (lo_b - lo_a) * {{(PIX_W-FRAC_W){1'b0}}, f};
        hi_p = (hi_b - hi_a) * {{(PIX_W-FRAC_W){1'b0}}, f};
        lo   = (lo_a + (lo_p >> 8)) & LANE_MASK_LO;
        hi   = ((hi_a + (hi_p >> 8)) << 8) & LANE_MASK_HI;
        return lo | hi;
    endfunction

    t_px_ctl          r_ctl;
    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_bot;
    logic             r_valid;
    logic             r_oor;
    logic [PIX_W-1:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ctl   <= i_ctl;
            r_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= lerp_pair(i_top_l, i_top_r, i_ctl.xf);
        r_bot     <= lerp_pair(i_bot_l, i_bot_r, i_ctl.xf);
        r_oor     <= r_ctl.oor;
        // drop the blend for coordinates outside the target
        r_pixel   <= r_ctl.oor ? '0 : lerp_pair(r_top, r_bot, r_ctl.yf);
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_oor   = r_oor;

endmodule
`default_nettype wire

### design/bilinear_image_resize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear image scaler with a parity-banked source image store.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. A load
// request (i_action low) writes i_pixel_in at (i_col, i_row) and gives no
// result. A compute request (i_action high) names a destination pixel; its
// result shows on o_pixel_out and o_out_of_range with o_valid high for one
// cycle, after the request, position, bank read and blend stages. While busy
// is low, one request per cycle is sustained, loads and computes mixed
// freely: the image is held in four banks by row and column parity, so the
// four neighbors of a position are read in the same cycle, one read port per bank.
// Size registers are written through i_cfg_we/i_cfg_index/i_cfg_data. After
// reset and after each register write, busy stays high while a shared-nothing
// pair of bit-serial dividers forms the horizontal and vertical 9.8 source
// steps (17 quotient bits, one per cycle). Reset clears the pipeline and
// sets all sizes to 256; image contents are not cleared.
// The receiver cannot stall: results are presented once and never held.
// ----------------------------------------------------------------------------
module bilinear_image_resize #(
    parameter int MAX_WIDTH  = rbi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbi_pkg::DEF_MAX_HEIGHT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          i_action,
    input  wire [rbi_pkg::PIX_W-1:0]     i_pixel_in,
    input  wire [rbi_pkg::COORD_W-1:0]   i_col,
    input  wire [rbi_pkg::COORD_W-1:0]   i_row,
    output logic                         o_valid,
    output logic [rbi_pkg::PIX_W-1:0]    o_pixel_out,
    output logic                         o_out_of_range,
    input  wire                          i_cfg_we,
    input  wire [rbi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [rbi_pkg::SIZE_W-1:0]    i_cfg_data
);
    import rbi_pkg::*;

    localparam int BANK_W     = (MAX_WIDTH + 1) / 2;
    localparam int BANK_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = BANK_W * BANK_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int HALF_W     = SIZE_W - 1;

    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [HALF_W-1:0] row_half,
        input logic [HALF_W-1:0] col_half
    );
        logic [31:0] lin;
        lin = 32'(row_half) * 32'(BANK_W) + 32'(col_half);
        return lin[BANK_AW-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input int                hi
    );
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (int'(v) > hi) begin
            return SIZE_W'(hi);
        end
        return v;
    endfunction

    // ---------------- configuration and step dividers ----------------
    logic [SIZE_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic              r_recalc;
    logic [SIZE_W-1:0] sw_c, sh_c, tw_c, th_c;
    logic              x_busy, y_busy;
    logic [POS_W-1:0]  xd, yd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= SIZE_RESET;
            r_src_h  <= SIZE_RESET;
            r_dst_w  <= SIZE_RESET;
            r_dst_h  <= SIZE_RESET;
            r_recalc <= 1'b1;
        end else begin
            r_recalc <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_W: r_src_w <= i_cfg_data;
                    CFG_SRC_H: r_src_h <= i_cfg_data;
                    CFG_DST_W: r_dst_w <= i_cfg_data;
                    CFG_DST_H: r_dst_h <= i_cfg_data;
                    default:   r_src_w <= r_src_w;
                endcase
            end
        end
    end

    always_comb begin
        sw_c = clamp_size(r_src_w, MAX_WIDTH);
        sh_c = clamp_size(r_src_h, MAX_HEIGHT);
        tw_c = clamp_size(r_dst_w, 511);
        th_c = clamp_size(r_dst_h, 511);
    end

    rbi_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc),
        .i_dividend ({sw_c, {FRAC_W{1'b0}}}),
        .i_divisor  (tw_c),
        .o_busy     (x_busy),
        .o_quot     (xd)
    );

    rbi_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc),
        .i_dividend ({sh_c, {FRAC_W{1'b0}}}),
        .i_divisor  (th_c),
        .o_busy     (y_busy),
        .o_quot     (yd)
    );

    assign busy = r_recalc | x_busy | y_busy;

    // ---------------- request accept and image load ----------------
    logic acc, acc_load, acc_comp, in_store, wr_en;
    logic [BANK_AW-1:0] wr_addr;

    // stage 1: request registered
    logic               r_s1_valid, r_s1_load;
    logic [COORD_W-1:0] r_s1_col, r_s1_row;
    logic [PIX_W-1:0]   r_s1_pixel;

    assign acc      = start & ~busy;
    assign acc_load = acc & ~i_action;
    assign acc_comp = acc & i_action;
    // hold the load write in the stage 1 register so a compute taken just before reads the old entry
    assign in_store = (int'(r_s1_col) < MAX_WIDTH) && (int'(r_s1_row) < MAX_HEIGHT);
    assign wr_en    = r_s1_load & in_store;
    assign wr_addr  = bank_addr(HALF_W'(r_s1_row[COORD_W-1:1]),
                                HALF_W'(r_s1_col[COORD_W-1:1]));

    // stage 2: source position and range flag
    logic               r_s2_valid, r_s2_oor;
    logic [POS_W-1:0]   r_s2_x, r_s2_y;
    logic [POS_W+COORD_W-1:0] x_full, y_full;
    logic               s1_oor;

    assign x_full = r_s1_col * xd;
    assign y_full = r_s1_row * yd;
    assign s1_oor = ({1'b0, r_s1_col} >= tw_c) || ({1'b0, r_s1_row} >= th_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_load  <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc_comp;
            r_s1_load  <= acc_load;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col   <= i_col;
        r_s1_row   <= i_row;
        r_s1_pixel <= i_pixel_in;
        r_s2_oor   <= s1_oor;
        r_s2_x     <= x_full[POS_W-1:0];
        r_s2_y     <= y_full[POS_W-1:0];
    end

    // ---------------- neighbor columns/rows and bank reads ----------------
    logic [SIZE_W-1:0] x0, y0, x1, y1;
    logic [SIZE_W:0]   x0_inc, y0_inc, sw_m1, sh_m1;

    always_comb begin
        x0     = r_s2_x[POS_W-1:FRAC_W];
        y0     = r_s2_y[POS_W-1:FRAC_W];
        x0_inc = {1'b0, x0} + 1'b1;
        y0_inc = {1'b0, y0} + 1'b1;
        sw_m1  = {1'b0, sw_c} - 1'b1;
        sh_m1  = {1'b0, sh_c} - 1'b1;
        // clamp the second neighbor to the last column or row
        x1     = (x0_inc < sw_m1) ? x0_inc[SIZE_W-1:0] : sw_m1[SIZE_W-1:0];
        y1     = (y0_inc < sh_m1) ? y0_inc[SIZE_W-1:0] : sh_m1[SIZE_W-1:0];
    end

    logic [PIX_W-1:0]   rd_data [4];
    logic [BANK_AW-1:0] rd_addr [4];

    for (genvar k = 0; k < 4; k++) begin : g_bank
        localparam logic PX = 1'(k % 2);
        localparam logic PY = 1'(k / 2);
        logic [SIZE_W-1:0] bc, br;

        always_comb begin
            bc         = (x0[0] == PX) ? x0 : x1;
            br         = (y0[0] == PY) ? y0 : y1;
            rd_addr[k] = bank_addr(br[SIZE_W-1:1], bc[SIZE_W-1:1]);
        end

        rbi_bank #(
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (wr_en && r_s1_row[0] == PY && r_s1_col[0] == PX),
            .i_waddr (wr_addr),
            .i_wdata (r_s1_pixel),
            .i_raddr (rd_addr[k]),
            .o_rdata (rd_data[k])
        );
    end

    // stage 3: bank data arrives with its control
    t_px_ctl r_s3_ctl;
    logic    r_s3_x0p, r_s3_x1p, r_s3_y0p, r_s3_y1p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else begin
            r_s3_ctl.valid <= r_s2_valid;
            r_s3_ctl.oor   <= r_s2_oor;
            r_s3_ctl.xf    <= r_s2_x[FRAC_W-1:0];
            r_s3_ctl.yf    <= r_s2_y[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_x0p     <= x0[0];
        r_s3_x1p     <= x1[0];
        r_s3_y0p     <= y0[0];
        r_s3_y1p     <= y1[0];
    end

    rbi_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_s3_ctl),
        .i_top_l  (rd_data[{r_s3_y0p, r_s3_x0p}]),
        .i_top_r  (rd_data[{r_s3_y0p, r_s3_x1p}]),
        .i_bot_l  (rd_data[{r_s3_y1p, r_s3_x0p}]),
        .i_bot_r  (rd_data[{r_s3_y1p, r_s3_x1p}]),
        .o_valid  (o_valid),
        .o_pixel  (o_pixel_out),
        .o_oor    (o_out_of_range)
    );

`ifndef SYNTHESIS
    a_compute_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action) |-> ##5 o_valid)
        else $error("compute request produced no result");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_action) |-> ##5 !o_valid)
        else $error("load request produced a result");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("register write did not hold off requests");
`endif

endmodule
`default_nettype wire
